### rtl/core/cpbw_pkg.sv
// Package for the clipped pixel blit writer: field widths, register indexes,
// depth and access-size codes, and the shared word and settings types.
// Depends on nothing; every other file imports it.
package cpbw_pkg;

  localparam int unsigned COLOR_W  = 32;
  localparam int unsigned BMP_W    = 8;
  localparam int unsigned ORG_W    = 13;
  localparam int unsigned POS_W    = ORG_W + 1;
  localparam int unsigned DIM_W    = 12;
  localparam int unsigned BPP_W    = 6;
  localparam int unsigned STRIDE_W = 14;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned SIZE_W   = 2;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned PROD_W   = DIM_W + STRIDE_W;
  localparam int unsigned COFF_W   = DIM_W + 2;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_BPP    = 3'd2;
  localparam logic [IDX_W-1:0] REG_STRIDE = 3'd3;
  localparam logic [IDX_W-1:0] REG_BASE   = 3'd4;

  localparam logic [BPP_W-1:0] BPP_8  = 6'd8;
  localparam logic [BPP_W-1:0] BPP_16 = 6'd16;
  localparam logic [BPP_W-1:0] BPP_32 = 6'd32;

  localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd2;

  localparam logic [DIM_W-1:0]    RST_WIDTH  = 12'd800;
  localparam logic [DIM_W-1:0]    RST_HEIGHT = 12'd480;
  localparam logic [BPP_W-1:0]    RST_BPP    = BPP_16;
  localparam logic [STRIDE_W-1:0] RST_STRIDE = 14'd1600;
  localparam logic [ADDR_W-1:0]   RST_BASE   = 32'd0;

  typedef struct packed {
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [BPP_W-1:0]    bpp;
    logic [STRIDE_W-1:0] stride;
    logic [ADDR_W-1:0]   base;
  } cfg_t;

  typedef struct packed {
    logic signed [ORG_W-1:0] origin_y;
    logic signed [ORG_W-1:0] origin_x;
    logic [BMP_W-1:0]        bitmap_row;
    logic [BMP_W-1:0]        bitmap_col;
    logic [COLOR_W-1:0]      pixel_color;
  } pix_t;

  typedef struct packed {
    logic              format_error;
    logic              write_enable;
    logic [SIZE_W-1:0] write_size;
    logic [DATA_W-1:0] write_data;
    logic [ADDR_W-1:0] write_address;
  } res_t;

  function automatic logic [15:0] rgb565(input logic [COLOR_W-1:0] c);
    rgb565 = {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

### rtl/core/cpbw_cfg_regs.sv
// Settings register file for the blit writer: five write-only registers.
// Depends on cpbw_pkg.
module cpbw_cfg_regs
  import cpbw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  cfg_nxt.width  = cfg_wdata[DIM_W-1:0];
        REG_HEIGHT: cfg_nxt.height = cfg_wdata[DIM_W-1:0];
        REG_BPP:    cfg_nxt.bpp    = cfg_wdata[BPP_W-1:0];
        REG_STRIDE: cfg_nxt.stride = cfg_wdata[STRIDE_W-1:0];
        REG_BASE:   cfg_nxt.base   = cfg_wdata[ADDR_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= RST_WIDTH;
      cfg_r.height <= RST_HEIGHT;
      cfg_r.bpp    <= RST_BPP;
      cfg_r.stride <= RST_STRIDE;
      cfg_r.base   <= RST_BASE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/cpbw_pixel_calc.sv
// Per-pixel datapath: screen position, clipping, depth decode, store data
// and byte address. Depends on cpbw_pkg.
module cpbw_pixel_calc
  import cpbw_pkg::*;
(
  input  pix_t pix,
  input  cfg_t cfg,
  output res_t res
);

  logic signed [POS_W-1:0] sx;
  logic signed [POS_W-1:0] sy;
  logic                    on_screen;
  logic                    depth_ok;
  logic [1:0]              shift;
  logic [SIZE_W-1:0]       size;
  logic [DATA_W-1:0]       data;
  logic [PROD_W-1:0]       row_off;
  logic [COFF_W-1:0]       col_off;

  assign sx = POS_W'(pix.origin_x) + $signed({{(POS_W-BMP_W){1'b0}}, pix.bitmap_col});
  assign sy = POS_W'(pix.origin_y) + $signed({{(POS_W-BMP_W){1'b0}}, pix.bitmap_row});

  assign on_screen = !sx[POS_W-1] && !sy[POS_W-1]
                   && (sx[POS_W-2:0] < {1'b0, cfg.width})
                   && (sy[POS_W-2:0] < {1'b0, cfg.height});

  always_comb begin
    depth_ok = 1'b1;
    shift    = 2'd0;
    size     = SIZE_BYTE;
    data     = '0;
    case (cfg.bpp)
      BPP_8: begin
        data = {24'd0, pix.pixel_color[7:0]};
      end
      BPP_16: begin
        shift = 2'd1;
        size  = SIZE_HALF;
        data  = {16'd0, rgb565(pix.pixel_color)};
      end
      BPP_32: begin
        shift = 2'd2;
        size  = SIZE_WORD;
        data  = pix.pixel_color;
      end
      default: depth_ok = 1'b0;
    endcase
  end

  assign row_off = PROD_W'(sy[DIM_W-1:0]) * PROD_W'(cfg.stride);
  assign col_off = {2'd0, sx[DIM_W-1:0]} << shift;

  always_comb begin
    res = '0;
    if (on_screen) begin
      if (depth_ok) begin
        res.write_enable  = 1'b1;
        res.write_size    = size;
        res.write_data    = data;
        res.write_address = cfg.base + ADDR_W'(row_off) + ADDR_W'(col_off);
      end else begin
        res.format_error = 1'b1;
      end
    end
  end

endmodule

### rtl/core/clipped_pixel_blit_writer_top.sv
// Top level of the clipped pixel blit writer: input word register, pixel
// datapath, result register. Depends on cpbw_pkg, cpbw_cfg_regs, cpbw_pixel_calc.
//
//   channel  dir  handshake          payload
//   in_      in   in_tvalid/tready   tdata: color, col, row, origin_x, origin_y
//   out_     out  out_tvalid/tready  tdata: address, data, size; tuser: we, err
//   cfg_     in   cfg_we             cfg_index, cfg_wdata
//
// One word per cycle unless out_ stalls; an accepted word passes through the
// input word register and the result register to out_. Synchronous active-low
// reset clears both valid flags and resets the settings. A stall on out_ holds
// the result register; in_tready drops only when both stages are full.
module clipped_pixel_blit_writer_top
  import cpbw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pixel_color[31:0], bitmap_col[39:32], bitmap_row[47:40],
  // origin_x[60:48], origin_y[73:61], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // write_address[31:0], write_data[63:32], write_size[65:64], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // write_enable[0], format_error[1]
  output logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  cfg_t cfg;
  pix_t in_pix;
  pix_t pix_r;
  res_t res;
  res_t res_r;
  logic pix_vld_r;
  logic pix_vld_nxt;
  logic res_vld_r;
  logic res_vld_nxt;
  logic res_ready;
  logic pix_ready;

  cpbw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign in_pix = in_tdata[$bits(pix_t)-1:0];

  assign res_ready = !res_vld_r || out_tready;
  assign pix_ready = !pix_vld_r || res_ready;
  assign in_tready = pix_ready;

  assign pix_vld_nxt = pix_ready ? in_tvalid : pix_vld_r;
  assign res_vld_nxt = res_ready ? pix_vld_r : res_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      pix_vld_r <= pix_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && pix_ready) begin
      pix_r <= in_pix;
    end
    if (pix_vld_r && res_ready) begin
      res_r <= res;
    end
  end

  cpbw_pixel_calc u_calc (
    .pix (pix_r),
    .cfg (cfg),
    .res (res)
  );

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {6'd0, res_r.write_size, res_r.write_data, res_r.write_address};
  assign out_tuser  = {res_r.format_error, res_r.write_enable};

endmodule

### rtl/core/cpbw_checker.sv
// Port-level checks for the blit writer result channel, bound to the top.
// Depends on cpbw_pkg and clipped_pixel_blit_writer_top.
module cpbw_checker
  import cpbw_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("write and format error together");

  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("dropped pixel carries nonzero payload");

  a_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_tdata[65:64] == SIZE_BYTE && out_tdata[63:40] == '0) ||
      (out_tdata[65:64] == SIZE_HALF && out_tdata[63:48] == '0) ||
      out_tdata[65:64] == SIZE_WORD)
    else $error("store data exceeds access size");

endmodule

bind clipped_pixel_blit_writer_top cpbw_checker u_cpbw_checker (.*);

### test/testbench.sv
// Self-checking testbench for clipped_pixel_blit_writer_top: predicts each framebuffer
// write (clipping, depth, address, RGB565 packing) and compares every output word.
// Depends on cpbw_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module testbench;
  import cpbw_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 60;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_we;
  logic [IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  logic [DIM_W-1:0]    cur_width  = RST_WIDTH;
  logic [DIM_W-1:0]    cur_height = RST_HEIGHT;
  logic [BPP_W-1:0]    cur_bpp    = RST_BPP;
  logic [STRIDE_W-1:0] cur_stride = RST_STRIDE;
  logic [ADDR_W-1:0]   cur_base   = RST_BASE;

  res_t pending_writes[$];
  int   errors     = 0;
  int   quiet      = 0;
  bit   idle_en    = 1'b1;
  bit   hold_req   = 1'b0;
  int   rx_hold    = 0;
  int   rx_gap     = 0;

  clipped_pixel_blit_writer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic res_t predict_write(input logic [COLOR_W-1:0] color,
                                         input logic [BMP_W-1:0] col,
                                         input logic [BMP_W-1:0] row,
                                         input logic signed [ORG_W-1:0] ox,
                                         input logic signed [ORG_W-1:0] oy);
    res_t        r;
    int          sx;
    int          sy;
    logic [31:0] bytes;
    r     = '0;
    bytes = 32'd0;
    sx    = int'(ox);
    sy    = int'(oy);
    sx    = sx + int'(col);
    sy    = sy + int'(row);
    if (sx >= 0 && sy >= 0 && sx < int'(cur_width) && sy < int'(cur_height)) begin
      case (cur_bpp)
        BPP_8: begin
          bytes        = 32'd1;
          r.write_size = SIZE_BYTE;
          r.write_data = {24'd0, color[7:0]};
        end
        BPP_16: begin
          bytes        = 32'd2;
          r.write_size = SIZE_HALF;
          r.write_data = {16'd0, color[23:19], color[15:10], color[7:3]};
        end
        BPP_32: begin
          bytes        = 32'd4;
          r.write_size = SIZE_WORD;
          r.write_data = color;
        end
        default: bytes = 32'd0;
      endcase
      if (bytes != 32'd0) begin
        r.write_enable  = 1'b1;
        r.write_address = cur_base + 32'(sy) * 32'(cur_stride) + 32'(sx) * bytes;
      end else begin
        r.format_error = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic send_pixel(input logic [COLOR_W-1:0] color, input logic [BMP_W-1:0] col,
                            input logic [BMP_W-1:0] row, input logic signed [ORG_W-1:0] ox,
                            input logic signed [ORG_W-1:0] oy);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, oy, ox, row, col, color};
    do @(posedge clk); while (!in_tready);
    pending_writes.push_back(predict_write(color, col, row, ox, oy));
    @(negedge clk);
  endtask

  task automatic drain_writes();
    in_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WIDTH:  cur_width  = val[DIM_W-1:0];
      REG_HEIGHT: cur_height = val[DIM_W-1:0];
      REG_BPP:    cur_bpp    = val[BPP_W-1:0];
      REG_STRIDE: cur_stride = val[STRIDE_W-1:0];
      REG_BASE:   cur_base   = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // checker: pop the oldest prediction for every accepted output word
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual tdata=%h tuser=%h",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want = pending_writes.pop_front();
        check_field("write_address", want.write_address, out_tdata[31:0]);
        check_field("write_data", want.write_data, out_tdata[63:32]);
        check_field("write_size", 32'(want.write_size), 32'(out_tdata[65:64]));
        check_field("write_enable", 32'(want.write_enable), 32'(out_tuser[0]));
        check_field("format_error", 32'(want.format_error), 32'(out_tuser[1]));
      end
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      rx_hold  = LONG_HOLD;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      rx_gap = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_reset_settings();
    send_pixel(32'hFFFF_FFFF, 8'd0, 8'd0, 13'sd0, 13'sd0);
    send_pixel(32'h00F8_1C07, 8'd255, 8'd255, 13'sd544, 13'sd224);
    send_pixel(32'h00AB_CDEF, 8'd255, 8'd0, 13'sd545, 13'sd0);
    send_pixel(32'h0012_3456, 8'd0, 8'd255, 13'sd0, 13'sd225);
    send_pixel(32'h00FF_FFFF, 8'd0, 8'd3, -13'sd1, 13'sd0);
    send_pixel(32'h8000_0001, 8'd255, 8'd255, -13'sd4096, -13'sd4096);
    send_pixel(32'h0000_0000, 8'd255, 8'd10, -13'sd255, -13'sd10);
    send_pixel(32'h5A5A_A5A5, 8'd255, 8'd255, 13'sd4095, 13'sd4095);
    drain_writes();
  endtask

  task automatic test_depths();
    set_reg(REG_BPP, 32'(BPP_8));
    send_pixel(32'hDEAD_BEEF, 8'd17, 8'd9, 13'sd100, 13'sd50);
    send_pixel(32'h0000_00FF, 8'd255, 8'd0, 13'sd544, 13'sd479);
    drain_writes();
    set_reg(REG_BPP, 32'(BPP_32));
    send_pixel(32'hFFFF_FFFF, 8'd1, 8'd1, 13'sd798, 13'sd478);
    send_pixel(32'h0102_0304, 8'd2, 8'd2, 13'sd0, 13'sd0);
    drain_writes();
    set_reg(REG_BPP, 32'd24);
    send_pixel(32'h00FF_00FF, 8'd5, 8'd5, 13'sd5, 13'sd5);
    send_pixel(32'h00FF_00FF, 8'd5, 8'd5, -13'sd100, 13'sd5);
    drain_writes();
    set_reg(REG_BPP, 32'd0);
    send_pixel(32'h0000_0011, 8'd0, 8'd0, 13'sd0, 13'sd0);
    drain_writes();
    set_reg(REG_BPP, 32'hFFFF_FFFF);
    send_pixel(32'h0000_0022, 8'd0, 8'd0, 13'sd1, 13'sd1);
    drain_writes();
    // writes past the last register must change nothing
    for (int i = int'(REG_BASE) + 1; i < (1 << IDX_W); i++) set_reg(IDX_W'(i), $urandom);
    set_reg(REG_BPP, 32'(BPP_16));
    send_pixel(32'h0077_8899, 8'd40, 8'd30, 13'sd7, 13'sd3);
    drain_writes();
  endtask

  task automatic test_extreme_settings();
    set_reg(REG_WIDTH, 32'd4095);
    set_reg(REG_HEIGHT, 32'd4095);
    set_reg(REG_STRIDE, 32'd16383);
    set_reg(REG_BASE, 32'hFFFF_FFF0);
    set_reg(REG_BPP, 32'(BPP_32));
    send_pixel(32'hCAFE_F00D, 8'd255, 8'd255, 13'sd3839, 13'sd3839);
    send_pixel(32'h1357_9BDF, 8'd0, 8'd0, 13'sd0, 13'sd0);
    send_pixel(32'h2468_ACE0, 8'd1, 8'd0, 13'sd4094, 13'sd0);
    drain_writes();
    set_reg(REG_WIDTH, 32'd0);
    send_pixel(32'h0000_0001, 8'd0, 8'd0, 13'sd0, 13'sd0);
    drain_writes();
    set_reg(REG_WIDTH, 32'd1);
    set_reg(REG_HEIGHT, 32'd0);
    send_pixel(32'h0000_0002, 8'd0, 8'd0, 13'sd0, 13'sd0);
    drain_writes();
  endtask

  task automatic randomize_settings();
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    logic [CFG_W-1:0] b;
    logic [CFG_W-1:0] s;
    logic [CFG_W-1:0] base;
    case ($urandom_range(0, 9))
      0: w = 32'd1;
      1: w = 32'd4095;
      2: w = 32'd0;
      3, 4: w = $urandom_range(1, 64);
      default: w = $urandom_range(1, 4095);
    endcase
    case ($urandom_range(0, 9))
      0: h = 32'd1;
      1: h = 32'd4095;
      2, 3: h = $urandom_range(1, 64);
      default: h = $urandom_range(1, 4095);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: b = 32'(BPP_8);
      3, 4, 5: b = 32'(BPP_16);
      6, 7: b = 32'(BPP_32);
      8: b = $urandom_range(0, 63);
      default: b = ($urandom_range(0, 1) != 0) ? 32'd63 : 32'd0;
    endcase
    case ($urandom_range(0, 4))
      0: s = 32'd0;
      1: s = 32'd16383;
      default: s = $urandom_range(0, 16383);
    endcase
    case ($urandom_range(0, 4))
      0: base = 32'd0;
      1: base = 32'hFFFF_FFFF;
      2: base = 32'hFFFF_FF00;
      default: base = $urandom;
    endcase
    set_reg(REG_WIDTH, ($urandom & 32'hFFFF_F000) | w);
    set_reg(REG_HEIGHT, ($urandom & 32'hFFFF_F000) | h);
    set_reg(REG_BPP, ($urandom & 32'hFFFF_FFC0) | b);
    set_reg(REG_STRIDE, ($urandom & 32'hFFFF_C000) | s);
    set_reg(REG_BASE, base);
  endtask

  task automatic send_random_pixel();
    logic [BMP_W-1:0]        col;
    logic [BMP_W-1:0]        row;
    logic signed [ORG_W-1:0] ox;
    logic signed [ORG_W-1:0] oy;
    int                      tx;
    int                      ty;
    col = BMP_W'($urandom);
    row = BMP_W'($urandom);
    ox  = ORG_W'($urandom);
    oy  = ORG_W'($urandom);
    // most pixels aim near the visible area so both edges get hit
    if ($urandom_range(0, 9) < 7) begin
      tx = int'($urandom_range(0, int'(cur_width) + 8)) - 4 - int'(col);
      ty = int'($urandom_range(0, int'(cur_height) + 8)) - 4 - int'(row);
      if (tx >= -4096 && tx <= 4095) ox = tx[ORG_W-1:0];
      if (ty >= -4096 && ty <= 4095) oy = ty[ORG_W-1:0];
    end
    send_pixel($urandom, col, row, ox, oy);
  endtask

  task automatic test_backpressure();
    set_reg(REG_WIDTH, 32'd64);
    set_reg(REG_HEIGHT, 32'd64);
    set_reg(REG_BPP, 32'(BPP_16));
    hold_req = 1'b1;
    repeat (40) send_random_pixel();
    drain_writes();
  endtask

  task automatic test_random_traffic(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      if (p == phases - 1) idle_en = 1'b0;
      randomize_settings();
      repeat (per_phase) send_random_pixel();
      drain_writes();
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_settings();
    test_depths();
    test_extreme_settings();
    test_backpressure();
    test_random_traffic(10, 110);
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/cpbw_pkg.sv
rtl/core/cpbw_cfg_regs.sv
rtl/core/cpbw_pixel_calc.sv
rtl/core/clipped_pixel_blit_writer_top.sv
rtl/core/cpbw_checker.sv
test/testbench.sv
